>>> rtl/core/assert_macros.svh
// assertion helpers shared by the rtl files
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// concurrent check on a named clock and active-low reset
`define ASSERT_CLK(lbl, clk, rst_n, prop, msg) \
  lbl: assert property (@(posedge clk) disable iff (!rst_n) prop) else $error(msg);

// concurrent check on the block clock and reset
`define ASSERT_DEF(lbl, prop, msg) \
  `ASSERT_CLK(lbl, clk_i, rst_ni, prop, msg)

`endif

>>> rtl/core/crs_pkg.sv
// ----------------------------------------------------------------------------
// crs_pkg
// shared sizes, register codes, types and helpers of the span rasterizer
// ----------------------------------------------------------------------------
package crs_pkg;

  // plot geometry and step limit
  localparam int COLUMNS  = 320;
  localparam int ROWS     = 240;
  localparam int MAX_STEP = 8;

  // derived widths
  localparam int COL_W  = $clog2(COLUMNS);
  localparam int CNT_W  = $clog2(COLUMNS + 1);
  localparam int ROW_W  = $clog2(ROWS);
  localparam int STEP_W = $clog2(MAX_STEP + 1);
  localparam int SPAN_W = $clog2(MAX_STEP + 1);

  // configuration register indexes
  localparam int CFG_IDX_W = 2;
  localparam logic [CFG_IDX_W-1:0] REG_Y_TOP    = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_ROW_SCALE = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_COL_STEP = 2'd2;

  // row mapping result handed to the sequencer
  typedef struct packed {
    logic             done;
    logic             on_screen;
    logic [ROW_W-1:0] row;
  } map_res_t;

  // column step with zero read as one and clamped to the limit
  function automatic logic [STEP_W-1:0] eff_step(input logic [3:0] s);
    logic [STEP_W-1:0] r;
    if (s == 4'd0) begin
      r = STEP_W'(1);
    end else if (int'(s) > MAX_STEP) begin
      r = STEP_W'(MAX_STEP);
    end else begin
      r = STEP_W'(s);
    end
    return r;
  endfunction

  // next column counter value, saturating at the column count
  function automatic logic [CNT_W-1:0] advance(input logic [CNT_W-1:0] col,
                                               input logic [3:0] s);
    logic [CNT_W+STEP_W-1:0] sum;
    logic [CNT_W-1:0]        r;
    sum = (CNT_W+STEP_W)'(col) + (CNT_W+STEP_W)'(eff_step(s));
    if (sum > (CNT_W+STEP_W)'(COLUMNS)) begin
      r = CNT_W'(COLUMNS);
    end else begin
      r = sum[CNT_W-1:0];
    end
    return r;
  endfunction

endpackage

>>> rtl/core/crs_sample_if.sv
// ----------------------------------------------------------------------------
// crs_sample_if
// sample channel: one evaluated curve value per beat
// ----------------------------------------------------------------------------
interface crs_sample_if;
  logic               valid;
  logic               ready;
  logic signed [31:0] sample_value;
  logic               sample_ok;
  logic               curve_start;

  modport source (output valid, output sample_value, output sample_ok,
                  output curve_start, input ready);
  modport sink (input valid, input sample_value, input sample_ok,
                input curve_start, output ready);
endinterface

>>> rtl/core/crs_span_if.sv
// ----------------------------------------------------------------------------
// crs_span_if
// span channel: one vertical pixel span per beat
// ----------------------------------------------------------------------------
interface crs_span_if;
  logic                      valid;
  logic                      ready;
  logic [crs_pkg::COL_W-1:0] span_column;
  logic [crs_pkg::ROW_W-1:0] row_top;
  logic [crs_pkg::ROW_W-1:0] row_bottom;
  logic                      last_span;

  modport source (output valid, output span_column, output row_top,
                  output row_bottom, output last_span, input ready);
  modport sink (input valid, input span_column, input row_top,
                input row_bottom, input last_span, output ready);
endinterface

>>> rtl/core/curve_column_span_rasterizer.sv
// ----------------------------------------------------------------------------
// curve_column_span_rasterizer
// turns evaluated curve samples into vertical pixel spans, column by column
// ----------------------------------------------------------------------------
// Use: samples arrive as beats on sample_i (valid/ready); spans leave as
// beats on span_o, one per column, the final one of a sample flagged by
// last_span. Configuration (y_top, row_scale, column_step) is to be written
// on the cfg_* port while the block is idle; the block does not enforce it.
// Timing: a sample is taken only in the idle state. A dropped or invalid
// sample leaves the block idle. A valid sample passes the row mapper
// (subtract on the input beat, magnitude, two passes of the shared 17x32
// multiplier, sum), and then the row is handed over; an off-screen one
// then returns to idle. A single-pixel result is loaded from the setup
// state; an interpolated one goes through setup, the restoring divider for
// ROW_W (8) quotient bits, then emits one span per cycle over the span
// columns unless the receiver stalls.
// The output register holds a finished span while the next sample is
// taken; when the receiver stalls the span sequencer waits with it.
// Reset: asynchronous, active low; column counter and line state clear,
// registers return to y_top 0, row_scale 1.0, column_step 1. No clearing
// pass is needed.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module curve_column_span_rasterizer (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          cfg_we_i,
  input  logic [crs_pkg::CFG_IDX_W-1:0] cfg_idx_i,
  input  logic [31:0]                   cfg_data_i,
  crs_sample_if.sink                    sample_i,
  crs_span_if.source                    span_o
);
  import crs_pkg::*;

  localparam logic [2:0] S_IDLE  = 3'd0;
  localparam logic [2:0] S_MAP   = 3'd1;
  localparam logic [2:0] S_SETUP = 3'd2;
  localparam logic [2:0] S_DIV   = 3'd3;
  localparam logic [2:0] S_SPAN  = 3'd4;

  localparam int DCNT_W = $clog2(ROW_W + 1);
  localparam int EW     = COL_W + SPAN_W;

  // configuration
  logic signed [31:0] y_top_q;
  logic [31:0]        row_scale_q;
  logic [3:0]         step_q;

  // control state
  logic [2:0]       st_q, st_d;
  logic [CNT_W-1:0] next_col_q, next_col_d;
  logic [COL_W-1:0] prior_col_q, prior_col_d;
  logic [ROW_W-1:0] prior_row_q, prior_row_d;
  logic             prior_ok_q, prior_ok_d;
  logic             out_valid_q;

  // per-sample working registers
  logic [COL_W-1:0]  col_q;
  logic              pok_q;
  logic [ROW_W-1:0]  row_q;
  logic [SPAN_W-1:0] span_q;
  logic              dneg_q;
  logic [ROW_W-1:0]  quo_q;
  logic [SPAN_W-1:0] rem_q;
  logic [DCNT_W-1:0] dcnt_q;
  logic [SPAN_W-1:0] k_q;
  logic [ROW_W-1:0]  qacc_q;
  logic [SPAN_W-1:0] racc_q;
  logic [ROW_W-1:0]  last_q;

  // output payload
  logic [COL_W-1:0] o_col_q;
  logic [ROW_W-1:0] o_top_q, o_bot_q;
  logic             o_last_q;

  logic             accept;
  logic [CNT_W-1:0] col_now;
  logic             pok_now;
  logic             col_live;
  logic             map_start;
  map_res_t         map_res;
  logic             slot_free;
  logic [COL_W-1:0] col_gap;
  logic             single;
  logic             commit;
  logic             load_single;
  logic             load_span;

  // divider step
  logic [SPAN_W:0]   div_t;
  logic              div_ge;
  logic [ROW_W:0]    div_qt;

  // span step
  logic [SPAN_W:0]   rsum;
  logic              carry;
  logic [SPAN_W-1:0] racc_nx;
  logic [ROW_W-1:0]  qacc_nx;
  logic [ROW_W-1:0]  cur;
  logic [EW-1:0]     ecol;

  // configuration writes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      y_top_q     <= 32'sd0;
      row_scale_q <= 32'd65536;
      step_q      <= 4'd1;
    end else if (cfg_we_i) begin
      unique case (cfg_idx_i)
        REG_Y_TOP:     y_top_q     <= cfg_data_i;
        REG_ROW_SCALE: row_scale_q <= cfg_data_i;
        REG_COL_STEP:  step_q      <= cfg_data_i[3:0];
        default:       ;
      endcase
    end
  end

  // input beat and curve start handling
  assign sample_i.ready = (st_q == S_IDLE);
  assign accept    = sample_i.valid && sample_i.ready;
  assign col_now   = sample_i.curve_start ? '0 : next_col_q;
  assign pok_now   = sample_i.curve_start ? 1'b0 : prior_ok_q;
  assign col_live  = (col_now < CNT_W'(COLUMNS));
  assign map_start = accept && col_live && sample_i.sample_ok;

  crs_row_map u_row_map (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .start_i     (map_start),
    .y_top_i     (y_top_q),
    .row_scale_i (row_scale_q),
    .value_i     (sample_i.sample_value),
    .res_o       (map_res)
  );

  // output register is free when empty or being taken
  assign slot_free = !out_valid_q || span_o.ready;

  // line continuation test
  assign col_gap = col_q - prior_col_q;
  assign single  = !pok_q || (prior_col_q >= col_q) || (int'(col_gap) > MAX_STEP);

  // restoring divider: one quotient bit a cycle
  assign div_t  = {rem_q, quo_q[ROW_W-1]};
  assign div_ge = (div_t >= {1'b0, span_q});
  assign div_qt = {quo_q, div_ge};

  // interpolation step: running quotient and remainder of k*|diff|/span
  assign rsum    = (SPAN_W+1)'(racc_q) + (SPAN_W+1)'(rem_q);
  assign carry   = (rsum >= {1'b0, span_q});
  assign racc_nx = carry ? SPAN_W'(rsum - {1'b0, span_q}) : rsum[SPAN_W-1:0];
  assign qacc_nx = ROW_W'((ROW_W+1)'(qacc_q) + (ROW_W+1)'(quo_q) + (ROW_W+1)'(carry));
  assign cur     = dneg_q ? ROW_W'(prior_row_q - qacc_nx) : ROW_W'(prior_row_q + qacc_nx);
  assign ecol    = EW'(prior_col_q) + EW'(k_q);

  assign load_single = (st_q == S_SETUP) && single && slot_free;
  assign load_span   = (st_q == S_SPAN) && slot_free;
  assign commit      = load_single || (load_span && (k_q == span_q));

  // sequencer and line state
  always_comb begin
    st_d        = st_q;
    next_col_d  = next_col_q;
    prior_col_d = prior_col_q;
    prior_row_d = prior_row_q;
    prior_ok_d  = prior_ok_q;
    unique case (st_q)
      S_IDLE: begin
        if (accept) begin
          if (sample_i.curve_start) begin
            next_col_d = '0;
            prior_ok_d = 1'b0;
          end
          if (col_live) begin
            if (sample_i.sample_ok) begin
              st_d = S_MAP;
            end else begin
              prior_ok_d = 1'b0;
              next_col_d = advance(col_now, step_q);
            end
          end
        end
      end
      S_MAP: begin
        if (map_res.done) begin
          if (map_res.on_screen) begin
            st_d = S_SETUP;
          end else begin
            prior_ok_d = 1'b0;
            next_col_d = advance(CNT_W'(col_q), step_q);
            st_d       = S_IDLE;
          end
        end
      end
      S_SETUP: begin
        if (!single) begin
          st_d = S_DIV;
        end else if (slot_free) begin
          st_d = S_IDLE;
        end
      end
      S_DIV: begin
        if (dcnt_q == '0) st_d = S_SPAN;
      end
      S_SPAN: begin
        if (commit) st_d = S_IDLE;
      end
      default: st_d = S_IDLE;
    endcase
    // sample finished: it becomes the previous plotted point
    if (commit) begin
      prior_col_d = col_q;
      prior_row_d = row_q;
      prior_ok_d  = 1'b1;
      next_col_d  = advance(CNT_W'(col_q), step_q);
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q        <= S_IDLE;
      next_col_q  <= '0;
      prior_col_q <= '0;
      prior_row_q <= '0;
      prior_ok_q  <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      st_q        <= st_d;
      next_col_q  <= next_col_d;
      prior_col_q <= prior_col_d;
      prior_row_q <= prior_row_d;
      prior_ok_q  <= prior_ok_d;
      if (load_single || load_span) begin
        out_valid_q <= 1'b1;
      end else if (span_o.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  // working registers and output payload
  always_ff @(posedge clk_i) begin
    if (accept) begin
      col_q <= col_now[COL_W-1:0];
      pok_q <= pok_now;
    end
    if (st_q == S_MAP && map_res.done) begin
      row_q <= map_res.row;
    end
    if (st_q == S_SETUP && !single) begin
      span_q <= SPAN_W'(col_gap);
      dneg_q <= (row_q < prior_row_q);
      quo_q  <= (row_q < prior_row_q) ? ROW_W'(prior_row_q - row_q)
                                      : ROW_W'(row_q - prior_row_q);
      rem_q  <= '0;
      dcnt_q <= DCNT_W'(ROW_W - 1);
      k_q    <= SPAN_W'(1);
      qacc_q <= '0;
      racc_q <= '0;
      last_q <= prior_row_q;
    end
    if (st_q == S_DIV) begin
      rem_q  <= div_ge ? SPAN_W'(div_t - {1'b0, span_q}) : div_t[SPAN_W-1:0];
      quo_q  <= div_qt[ROW_W-1:0];
      dcnt_q <= dcnt_q - DCNT_W'(1);
    end
    if (load_single) begin
      o_col_q  <= col_q;
      o_top_q  <= row_q;
      o_bot_q  <= row_q;
      o_last_q <= 1'b1;
    end
    if (load_span) begin
      o_col_q  <= ecol[COL_W-1:0];
      o_top_q  <= (last_q < cur) ? last_q : cur;
      o_bot_q  <= (last_q < cur) ? cur : last_q;
      o_last_q <= (k_q == span_q);
      qacc_q   <= qacc_nx;
      racc_q   <= racc_nx;
      last_q   <= cur;
      k_q      <= k_q + SPAN_W'(1);
    end
  end

  assign span_o.valid       = out_valid_q;
  assign span_o.span_column = o_col_q;
  assign span_o.row_top     = o_top_q;
  assign span_o.row_bottom  = o_bot_q;
  assign span_o.last_span   = o_last_q;

  `ASSERT_DEF(a_span_order, span_o.valid |-> span_o.row_top <= span_o.row_bottom,
              "span top below bottom")
  `ASSERT_DEF(a_div_nonzero, st_q == S_DIV |-> span_q != '0, "divide by zero span")
  `ASSERT_DEF(a_commit_line, commit |=> st_q == S_IDLE && prior_ok_q,
              "finished sample did not continue the line")

endmodule

>>> rtl/core/crs_row_map.sv
// ----------------------------------------------------------------------------
// crs_row_map
// maps a q16.16 value to a screen row with one shared 17x32 multiplier
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module crs_row_map (
  input  logic                clk_i,
  input  logic                rst_ni,
  input  logic                start_i,
  input  logic signed [31:0]  y_top_i,
  input  logic [31:0]         row_scale_i,
  input  logic signed [31:0]  value_i,
  output crs_pkg::map_res_t   res_o
);
  import crs_pkg::*;

  localparam logic [2:0] M_IDLE = 3'd0;
  localparam logic [2:0] M_ABS  = 3'd1;
  localparam logic [2:0] M_MH   = 3'd2;
  localparam logic [2:0] M_ML   = 3'd3;
  localparam logic [2:0] M_SUM  = 3'd4;

  logic [2:0]         st_q, st_d;
  logic signed [32:0] diff_q;
  logic               neg_q;
  logic [32:0]        mag_q;
  logic [48:0]        prod_q;
  logic [48:0]        acc_q;
  logic [16:0]        mul_a;
  logic [48:0]        prod_w;
  logic [65:0]        sum_w;
  logic [33:0]        whole_w;
  logic               done_q;
  logic               on_screen_q;
  logic [ROW_W-1:0]   row_q;

  // sequencer
  always_comb begin
    st_d = st_q;
    unique case (st_q)
      M_IDLE:  if (start_i) st_d = M_ABS;
      M_ABS:   st_d = M_MH;
      M_MH:    st_d = M_ML;
      M_ML:    st_d = M_SUM;
      M_SUM:   st_d = M_IDLE;
      default: st_d = M_IDLE;
    endcase
  end

  // shared multiplier: upper magnitude slice first, then the lower one
  assign mul_a  = (st_q == M_MH) ? mag_q[32:16] : {1'b0, mag_q[15:0]};
  assign prod_w = 49'(mul_a) * 49'(row_scale_i);

  // recombine partial products, keep the whole rows
  assign sum_w   = {1'b0, acc_q, 16'b0} + 66'(prod_q);
  assign whole_w = sum_w[65:32];

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      st_q   <= M_IDLE;
      done_q <= 1'b0;
    end else begin
      st_q   <= st_d;
      done_q <= (st_q == M_SUM);
    end
  end

  // datapath
  always_ff @(posedge clk_i) begin
    if (st_q == M_IDLE && start_i) begin
      diff_q <= 33'(y_top_i) - 33'(value_i);
    end
    if (st_q == M_ABS) begin
      neg_q <= diff_q[32];
      mag_q <= diff_q[32] ? 33'(-diff_q) : 33'(diff_q);
    end
    if (st_q == M_MH || st_q == M_ML) begin
      prod_q <= prod_w;
    end
    if (st_q == M_ML) begin
      acc_q <= prod_q;
    end
    if (st_q == M_SUM) begin
      // a negative value under one row still lands on the top row
      if (neg_q) begin
        on_screen_q <= (whole_w == 34'd0);
        row_q       <= '0;
      end else begin
        on_screen_q <= (whole_w < 34'(ROWS));
        row_q       <= whole_w[ROW_W-1:0];
      end
    end
  end

  assign res_o = {done_q, on_screen_q, row_q};

  `ASSERT_DEF(a_start_idle, start_i |-> st_q == M_IDLE, "row map started while busy")
  `ASSERT_DEF(a_done_after_sum, done_q |-> $past(st_q) == M_SUM,
              "row map result without final stage")

endmodule
